// ===== hw/rtl/dtef_pkg.sv =====
// Shared types, constants and fixed-point helpers of the evidence fusion block.
`default_nettype none
package dtef_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int MAX_MODELS  = 4;
    localparam int FRAC_BITS   = 15;

    localparam int CLS_W = 3;
    localparam int MDL_W = 2;
    localparam int VAL_W = 16;
    localparam int NC_W  = 4;
    localparam int NM_W  = 3;

    localparam int TPL_DEPTH = MAX_CLASSES * MAX_MODELS * MAX_CLASSES;
    localparam int PRF_DEPTH = MAX_MODELS * MAX_CLASSES;

    localparam int NUM_W  = 32;
    localparam int DEN_W  = 20;
    localparam int DIST_W = 35;
    localparam int SUM_W  = 19;

    localparam logic [VAL_W-1:0] FX_ONE     = VAL_W'(1 << FRAC_BITS);
    localparam logic [NUM_W-1:0] RECIP_NUM  = NUM_W'(1 << (2 * FRAC_BITS));
    localparam logic [NUM_W-1:0] FX_HALF32  = NUM_W'(1 << (FRAC_BITS - 1));

    localparam logic KIND_TEMPLATE = 1'b0;
    localparam logic KIND_PROFILE  = 1'b1;

    localparam logic [1:0] CFG_CLASS_COUNT = 2'd0;
    localparam logic [1:0] CFG_MODEL_COUNT = 2'd1;

    typedef struct packed {
        logic             kind;
        logic [CLS_W-1:0] template_class;
        logic [MDL_W-1:0] model_index;
        logic [CLS_W-1:0] element_index;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [CLS_W-1:0] class_index;
        logic [VAL_W-1:0] support;
        logic             last_result;
        logic             tie;
        logic [CLS_W-1:0] winner;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    // Rounded Q1.15 product, half up
    function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [NUM_W-1:0] p;
        p = NUM_W'(a) * NUM_W'(b) + FX_HALF32;
        return p[FRAC_BITS +: VAL_W];
    endfunction

    // Clamp a quotient to 1.0
    function automatic logic [VAL_W-1:0] sat_one(input logic [NUM_W-1:0] q);
        return (q > NUM_W'(FX_ONE)) ? FX_ONE : q[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/decision_template_evidence_fusion.sv =====
// Top level: decision-template evidence fusion sequencer around three RAMs and a divider.
// Template and profile beats are written to their RAMs as accepted; the input is held off during fusion.
// Every division of a fusion runs on the one shared bit-serial divider, one at a time.
// The first result is emitted only after the beliefs of every class and model are computed.
// Reset (synchronous, active low) clears the sequencer, sets 8 classes and 4 models, keeps RAMs.
`default_nettype none
module decision_template_evidence_fusion (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dtef_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dtef_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [3:0]     i_cfg_data
);
    import dtef_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_ACC, S_RECIP, S_RECIP_W, S_PROX, S_PROX_W,
        S_MULT, S_NUM, S_DEN, S_BEL, S_BEL_W,
        S_BRD, S_NRM, S_NRM_W, S_SMUL, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0] r_class_count;
    logic [2:0] r_model_count;
    logic [NC_W-1:0] nc;
    logic [NM_W-1:0] nm;

    // loop counters
    logic [CLS_W-1:0] r_c, r_k, r_e;
    logic [MDL_W-1:0] r_m;

    // datapath registers
    logic [DIST_W-1:0] r_dist;
    logic [SUM_W-1:0]  r_sum;
    logic [VAL_W-1:0]  r_recip [MAX_CLASSES];
    logic [VAL_W-1:0]  r_prox  [MAX_CLASSES];
    logic [VAL_W-1:0]  r_mult, r_num, r_t, r_bn, r_s;
    logic [VAL_W-1:0]  r_bmin, r_bmax, r_best;
    logic [CLS_W-1:0]  r_winner;
    logic              r_tie;

    // output register
    logic r_ov;
    t_out r_out;

    // RAM ports
    logic                      tpl_we, prf_we, bel_we;
    logic [VAL_W-1:0]          in_val, tpl_rdata, prf_rdata, bel_rdata, bel_wdata;
    logic [$clog2(TPL_DEPTH)-1:0] tpl_waddr, tpl_raddr;
    logic [$clog2(PRF_DEPTH)-1:0] prf_waddr, prf_raddr, bel_addr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic             in_acc, out_acc, out_load;
    logic             last_c, last_e, last_k, last_m;
    logic [CLS_W-1:0] rd_idx;
    logic [VAL_W-1:0] prox_rd, diff, div_q, range_w;
    logic [NUM_W-1:0] sq;
    logic [DEN_W-1:0] dist_rnd;
    logic             new_best, eq_best;
    logic [VAL_W-1:0] n_best;
    logic [CLS_W-1:0] n_winner;
    logic             n_tie;

    // saturate the register counts into the usable range
    always_comb begin
        if (r_class_count < 4'd2) begin
            nc = 4'd2;
        end else if (r_class_count > 4'(MAX_CLASSES)) begin
            nc = 4'(MAX_CLASSES);
        end else begin
            nc = r_class_count;
        end
        if (r_model_count < 3'd1) begin
            nm = 3'd1;
        end else if (r_model_count > 3'(MAX_MODELS)) begin
            nm = 3'(MAX_MODELS);
        end else begin
            nm = r_model_count;
        end
    end

    assign last_c = ({1'b0, r_c} == nc - 4'd1);
    assign last_e = ({1'b0, r_e} == nc - 4'd1);
    assign last_k = ({1'b0, r_k} == nc - 4'd1);
    assign last_m = ({1'b0, r_m} == nm - 3'd1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_ov && i_out_ready;
    assign out_load    = (r_state == S_OUT) && (!r_ov || i_out_ready);

    // clamp input words to 1.0 and place them in the stores
    assign in_val    = (i_in_data.value > FX_ONE) ? FX_ONE : i_in_data.value;
    assign tpl_we    = in_acc && (i_in_data.kind == KIND_TEMPLATE);
    assign prf_we    = in_acc && (i_in_data.kind == KIND_PROFILE);
    assign tpl_waddr = {i_in_data.template_class, i_in_data.model_index,
                        i_in_data.element_index};
    assign prf_waddr = {i_in_data.model_index, i_in_data.element_index};
    assign tpl_raddr = {r_c, r_m, r_e};
    assign prf_raddr = {r_m, r_e};
    assign bel_addr  = {r_m, r_c};

    assign div_q     = sat_one(div_rsp.quo);
    assign bel_we    = (r_state == S_BEL_W) && div_rsp.done;
    assign bel_wdata = div_q;

    // one read port on the proximity row: index k while building the product, else c
    assign rd_idx  = (r_state == S_MULT) ? r_k : r_c;
    assign prox_rd = r_prox[rd_idx];

    assign diff     = (tpl_rdata > prf_rdata) ? (tpl_rdata - prf_rdata)
                                              : (prf_rdata - tpl_rdata);
    assign sq       = NUM_W'(diff) * NUM_W'(diff);
    assign dist_rnd = DEN_W'((r_dist + DIST_W'(FX_HALF32)) >> FRAC_BITS);
    assign range_w  = r_bmax - r_bmin;

    // divider operands per phase
    always_comb begin
        div_req = '0;
        case (r_state)
            S_RECIP: begin
                div_req.start = 1'b1;
                div_req.num   = RECIP_NUM;
                div_req.den   = DEN_W'(FX_ONE) + dist_rnd;
            end
            S_PROX: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(r_recip[r_c]) << FRAC_BITS;
                div_req.den   = DEN_W'(r_sum);
            end
            S_BEL: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(r_num) << FRAC_BITS;
                div_req.den   = (r_t < FX_ONE) ? DEN_W'(FX_ONE - r_t) : '0;
            end
            S_NRM: begin
                div_req.start = (range_w != '0);
                div_req.num   = NUM_W'(bel_rdata - r_bmin) << FRAC_BITS;
                div_req.den   = DEN_W'(range_w);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    // running maximum; a later class with an equal support takes the win
    always_comb begin
        new_best = (r_c == '0) || (r_s > r_best);
        eq_best  = (r_s == r_best);
        n_best   = r_best;
        n_winner = r_winner;
        n_tie    = r_tie;
        if (new_best) begin
            n_best   = r_s;
            n_winner = r_c;
            n_tie    = 1'b0;
        end else if (eq_best) begin
            n_winner = r_c;
            n_tie    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_class_count <= 4'd8;
            r_model_count <= 3'd4;
            r_ov          <= 1'b0;
            r_s           <= FX_ONE;
            r_mult        <= FX_ONE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLASS_COUNT: r_class_count <= i_cfg_data;
                    CFG_MODEL_COUNT: r_model_count <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (out_acc && !out_load) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.kind == KIND_PROFILE && i_in_data.last) begin
                        r_m     <= '0;
                        r_c     <= '0;
                        r_e     <= '0;
                        r_dist  <= '0;
                        r_sum   <= '0;
                        r_state <= S_RD;
                    end
                end
                // squared distance between template row and profile row
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_dist <= r_dist + DIST_W'(sq);
                    if (last_e) begin
                        r_state <= S_RECIP;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RECIP: begin
                    r_state <= S_RECIP_W;
                end
                S_RECIP_W: begin
                    if (div_rsp.done) begin
                        r_recip[r_c] <= div_q;
                        r_sum        <= r_sum + SUM_W'(div_q);
                        if (last_c) begin
                            r_c     <= '0;
                            r_state <= S_PROX;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_e     <= '0;
                            r_dist  <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                // normalise the proximities over the classes
                S_PROX: begin
                    r_state <= S_PROX_W;
                end
                S_PROX_W: begin
                    if (div_rsp.done) begin
                        r_prox[r_c] <= div_q;
                        if (last_c) begin
                            r_c     <= '0;
                            r_k     <= '0;
                            r_mult  <= FX_ONE;
                            r_state <= S_MULT;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_PROX;
                        end
                    end
                end
                // product of (1 - proximity) over the other classes
                S_MULT: begin
                    if (r_k != r_c) begin
                        r_mult <= fx_mul(r_mult, FX_ONE - prox_rd);
                    end
                    if (last_k) begin
                        r_state <= S_NUM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NUM: begin
                    r_num   <= fx_mul(prox_rd, r_mult);
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_t     <= fx_mul(prox_rd, FX_ONE - r_mult);
                    r_state <= S_BEL;
                end
                S_BEL: begin
                    r_state <= S_BEL_W;
                end
                S_BEL_W: begin
                    if (div_rsp.done) begin
                        if ((r_m == '0 && r_c == '0) || div_q > r_bmax) begin
                            r_bmax <= div_q;
                        end
                        if ((r_m == '0 && r_c == '0) || div_q < r_bmin) begin
                            r_bmin <= div_q;
                        end
                        if (!last_c) begin
                            r_c     <= r_c + 1'b1;
                            r_k     <= '0;
                            r_mult  <= FX_ONE;
                            r_state <= S_MULT;
                        end else if (!last_m) begin
                            r_m     <= r_m + 1'b1;
                            r_c     <= '0;
                            r_e     <= '0;
                            r_dist  <= '0;
                            r_sum   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_m     <= '0;
                            r_c     <= '0;
                            r_s     <= FX_ONE;
                            r_state <= S_BRD;
                        end
                    end
                end
                // min-max normalise each belief on read and fold it into the support
                S_BRD: begin
                    r_state <= S_NRM;
                end
                S_NRM: begin
                    if (range_w == '0) begin
                        r_bn    <= '0;
                        r_state <= S_SMUL;
                    end else begin
                        r_state <= S_NRM_W;
                    end
                end
                S_NRM_W: begin
                    if (div_rsp.done) begin
                        r_bn    <= div_q;
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    r_s <= fx_mul(r_s, r_bn);
                    if (last_m) begin
                        r_state <= S_OUT;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                // hold until the output register is free, then emit one beat
                S_OUT: begin
                    if (out_load) begin
                        r_ov                <= 1'b1;
                        r_out.class_index   <= r_c;
                        r_out.support       <= r_s;
                        r_out.last_result   <= last_c;
                        r_out.tie           <= last_c && n_tie;
                        r_out.winner        <= last_c ? n_winner : '0;
                        r_best              <= n_best;
                        r_winner            <= n_winner;
                        r_tie               <= n_tie;
                        if (last_c) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_m     <= '0;
                            r_s     <= FX_ONE;
                            r_state <= S_BRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    dtef_ram #(.WIDTH(VAL_W), .DEPTH(TPL_DEPTH)) u_tpl_ram (
        .i_clk   (i_clk),
        .i_we    (tpl_we),
        .i_waddr (tpl_waddr),
        .i_wdata (in_val),
        .i_raddr (tpl_raddr),
        .o_rdata (tpl_rdata)
    );

    dtef_ram #(.WIDTH(VAL_W), .DEPTH(PRF_DEPTH)) u_prf_ram (
        .i_clk   (i_clk),
        .i_we    (prf_we),
        .i_waddr (prf_waddr),
        .i_wdata (in_val),
        .i_raddr (prf_raddr),
        .o_rdata (prf_rdata)
    );

    dtef_ram #(.WIDTH(VAL_W), .DEPTH(PRF_DEPTH)) u_bel_ram (
        .i_clk   (i_clk),
        .i_we    (bel_we),
        .i_waddr (bel_addr),
        .i_wdata (bel_wdata),
        .i_raddr (bel_addr),
        .o_rdata (bel_rdata)
    );

    dtef_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_rsp.busy) else $error("divider busy while taking input");
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BRD |-> r_bmin <= r_bmax) else $error("belief min above max");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_result |-> !o_out_data.tie && o_out_data.winner == '0)
        else $error("tie or winner on a non-final beat");
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s <= FX_ONE && r_mult <= FX_ONE) else $error("product above one");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/dtef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dtef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== hw/rtl/dtef_div.sv =====
// Bit-serial rounded divider: (num + den/2) / den, zero for a zero divisor.
`default_nettype none
module dtef_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dtef_pkg::t_div_req i_req,
    output dtef_pkg::t_div_rsp     o_rsp
);
    import dtef_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_zero;

    logic [DEN_W:0] rem_sh;
    logic           ge;
    logic [DEN_W:0] rem_new;

    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_new = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_q    <= i_req.num + NUM_W'(i_req.den >> 1);
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_zero <= (i_req.den == '0);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= rem_new[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_zero ? '0 : r_q;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a running division");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done) else $error("divider stopped early");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != 5'd31 |=> r_busy) else $error("divider dropped busy mid-run");
`endif
endmodule
`default_nettype wire
